### rtl/core/lbmw_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q5 wave
// collide-and-stream block. Used by every module in rtl/core.
package lbmw_pkg;

  localparam int GRID_X     = 128;
  localparam int GRID_Y     = 128;
  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam int CW  = 7;                 // coordinate field width
  localparam int VW  = VALUE_BITS;        // distribution width
  localparam int DW  = VW + 1;            // exact difference width
  localparam int TW  = 18;                // Q2.16 factor width
  localparam int C2W = 16;                // Q0.16 factor width
  localparam int PW  = DW + 2;            // rounded product width
  localparam int SW  = VW + 4;            // wide intermediate width

  localparam int NDIR      = 5;
  localparam int DIRW      = 3;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = TW;

  localparam logic [DIRW-1:0] DIR_REST  = 3'd0;
  localparam logic [DIRW-1:0] DIR_EAST  = 3'd1;
  localparam logic [DIRW-1:0] DIR_NORTH = 3'd2;
  localparam logic [DIRW-1:0] DIR_WEST  = 3'd3;
  localparam logic [DIRW-1:0] DIR_SOUTH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_C_SQUARED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU   = 4'd1;

  localparam logic [C2W-1:0] C_SQUARED_RST = 16'd16384;
  localparam logic [TW-1:0]  INV_TAU_RST   = 18'd131072;

  typedef struct packed {
    logic [CW-1:0]             x;
    logic [CW-1:0]             y;
    logic [NDIR-1:0][VW-1:0]   f;
    logic                      src;
    logic signed [VW-1:0]      rho;
    logic signed [VW-1:0]      jx;
    logic signed [VW-1:0]      jy;
    logic signed [PW-1:0]      c2r;
  } cell_t;

  // saturate a wide signed value to the distribution range
  function automatic logic signed [VW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [VW-1:0] r;
    if (!v[SW-1] && (|v[SW-2:VW-1])) begin
      r = {1'b0, {(VW-1){1'b1}}};
    end else if (v[SW-1] && !(&v[SW-2:VW-1])) begin
      r = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  // a * t / 2^16, round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] mulq(input logic signed [DW-1:0] a,
                                                input logic [TW-1:0] t);
    logic [DW-1:0]    m;
    logic [DW+TW-1:0] p;
    logic [DW+TW-1:0] r;
    logic [PW-1:0]    q;
    m = a[DW-1] ? DW'(-a) : DW'(a);
    p = (DW+TW)'(m) * (DW+TW)'(t);
    r = (p + (DW+TW)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    q = PW'(r);
    return a[DW-1] ? PW'(-q) : q;
  endfunction

  // s * 0.5, round to nearest, ties away from zero
  function automatic logic signed [SW-1:0] halfq(input logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    logic [SW-1:0] q;
    m = s[SW-1] ? SW'(-s) : SW'(s);
    q = (m + SW'(1)) >> 1;
    return s[SW-1] ? SW'(-q) : q;
  endfunction

endpackage

### rtl/core/lbmw_front.sv
// Front end: accepts cell beats, forms rho (the source density for source cells), Jx, Jy and c2*rho.
// Depends on lbmw_pkg; feeds lbmw_queue.
module lbmw_front import lbmw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic [C2W-1:0]        c_squared,
  output logic                  q_valid,
  input  logic                  q_ready,
  output cell_t                 q_entry
);

  logic                   a_valid_r;
  logic [CW-1:0]          a_x_r, a_y_r;
  logic [NDIR-1:0][VW-1:0] a_f_r;
  logic                   a_src_r;
  logic signed [VW-1:0]   a_sd_r;

  logic                   b_valid_r;
  logic [CW-1:0]          b_x_r, b_y_r;
  logic [NDIR-1:0][VW-1:0] b_f_r;
  logic                   b_src_r;
  logic signed [VW-1:0]   b_rho_r, b_jx_r, b_jy_r;

  logic                   c_valid_r;
  cell_t                  c_entry_r;

  logic                   en;
  logic signed [VW-1:0]   rho_nxt, jx_nxt, jy_nxt;
  logic signed [VW-1:0]   fr, fe, fn, fw, fs;

  assign en        = !c_valid_r || q_ready;
  assign in_tready = en;
  assign q_valid   = c_valid_r;
  assign q_entry   = c_entry_r;

  assign fr = a_f_r[DIR_REST];
  assign fe = a_f_r[DIR_EAST];
  assign fn = a_f_r[DIR_NORTH];
  assign fw = a_f_r[DIR_WEST];
  assign fs = a_f_r[DIR_SOUTH];

  always_comb begin
    rho_nxt = sat(SW'(fr) + SW'(fe) + SW'(fn) + SW'(fw) + SW'(fs));
    if (a_src_r) begin
      rho_nxt = a_sd_r;
    end
    jx_nxt = sat(SW'(fe) - SW'(fw));
    jy_nxt = sat(SW'(fn) - SW'(fs));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_tvalid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= CW'(in_tdata[6:0] % GRID_X);
      a_y_r    <= CW'(in_tdata[13:7] % GRID_Y);
      a_f_r[DIR_REST]  <= in_tdata[37:14];
      a_f_r[DIR_EAST]  <= in_tdata[61:38];
      a_f_r[DIR_NORTH] <= in_tdata[85:62];
      a_f_r[DIR_WEST]  <= in_tdata[109:86];
      a_f_r[DIR_SOUTH] <= in_tdata[133:110];
      a_sd_r   <= in_tdata[157:134];
      a_src_r  <= in_tuser;

      b_x_r    <= a_x_r;
      b_y_r    <= a_y_r;
      b_f_r    <= a_f_r;
      b_src_r  <= a_src_r;
      b_rho_r  <= rho_nxt;
      b_jx_r   <= jx_nxt;
      b_jy_r   <= jy_nxt;

      c_entry_r.x   <= b_x_r;
      c_entry_r.y   <= b_y_r;
      c_entry_r.f   <= b_f_r;
      c_entry_r.src <= b_src_r;
      c_entry_r.rho <= b_rho_r;
      c_entry_r.jx  <= b_jx_r;
      c_entry_r.jy  <= b_jy_r;
      c_entry_r.c2r <= mulq(DW'(b_rho_r), TW'(c_squared));
    end
  end

endmodule

### rtl/core/lbmw_queue.sv
// Four-entry queue of classified cells between front and back end.
// Depends on lbmw_pkg for the entry type.
module lbmw_queue import lbmw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  cell_t push_entry,
  output logic  head_valid,
  input  logic  pop,
  output cell_t head_entry
);

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  cell_t            mem_r [QD];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (QAW+1)'(QD));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/core/lbmw_back.sv
// Back end: walks the five directions of the head cell, forms the
// equilibrium, relaxes it (source cells take the equilibrium) and streams the result. Depends on lbmw_pkg.
module lbmw_back import lbmw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  cell_t                  head_entry,
  output logic                   pop,
  input  logic [TW-1:0]          inv_tau,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic [DIRW-1:0]        out_tuser,
  output logic                   out_tlast
);

  logic                 en, take;
  logic [DIRW-1:0]      dir_r;

  logic                 s1_valid_r;
  logic [DIRW-1:0]      s1_dir_r;
  logic [CW-1:0]        s1_dx_r, s1_dy_r;
  logic signed [VW-1:0] s1_f_r, s1_eq_r;
  logic signed [DW-1:0] s1_diff_r;
  logic                 s1_src_r;

  logic                 s2_valid_r;
  logic [DIRW-1:0]      s2_dir_r;
  logic [CW-1:0]        s2_dx_r, s2_dy_r;
  logic signed [VW-1:0] s2_f_r, s2_eq_r;
  logic signed [PW-1:0] s2_q_r;
  logic                 s2_src_r;

  logic                 out_valid_r;
  logic [DIRW-1:0]      out_dir_r;
  logic [CW-1:0]        out_dx_r, out_dy_r;
  logic signed [VW-1:0] out_post_r;

  logic signed [VW-1:0] f_nxt, eq_nxt, post_nxt;
  logic [CW-1:0]        dx_nxt, dy_nxt;
  logic [CW-1:0]        xp, xm, yp, ym;

  assign en   = !out_valid_r || out_tready;
  assign take = en && head_valid;
  assign pop  = take && (dir_r == DIR_SOUTH);

  assign xp = (head_entry.x == CW'(GRID_X - 1)) ? '0 : head_entry.x + 1'b1;
  assign xm = (head_entry.x == '0) ? CW'(GRID_X - 1) : head_entry.x - 1'b1;
  assign yp = (head_entry.y == CW'(GRID_Y - 1)) ? '0 : head_entry.y + 1'b1;
  assign ym = (head_entry.y == '0) ? CW'(GRID_Y - 1) : head_entry.y - 1'b1;

  always_comb begin
    dx_nxt = head_entry.x;
    dy_nxt = head_entry.y;
    case (dir_r)
      DIR_REST: begin
        f_nxt  = head_entry.f[DIR_REST];
        eq_nxt = sat(SW'(head_entry.rho) - SW'(head_entry.c2r) - SW'(head_entry.c2r));
      end
      DIR_EAST: begin
        f_nxt  = head_entry.f[DIR_EAST];
        eq_nxt = sat(halfq(SW'(head_entry.c2r) + SW'(head_entry.jx)));
        dx_nxt = xp;
      end
      DIR_NORTH: begin
        f_nxt  = head_entry.f[DIR_NORTH];
        eq_nxt = sat(halfq(SW'(head_entry.c2r) + SW'(head_entry.jy)));
        dy_nxt = yp;
      end
      DIR_WEST: begin
        f_nxt  = head_entry.f[DIR_WEST];
        eq_nxt = sat(halfq(SW'(head_entry.c2r) - SW'(head_entry.jx)));
        dx_nxt = xm;
      end
      DIR_SOUTH: begin
        f_nxt  = head_entry.f[DIR_SOUTH];
        eq_nxt = sat(halfq(SW'(head_entry.c2r) - SW'(head_entry.jy)));
        dy_nxt = ym;
      end
      default: begin
        f_nxt  = '0;
        eq_nxt = '0;
      end
    endcase
  end

  assign post_nxt = s2_src_r ? s2_eq_r : sat(SW'(s2_f_r) + SW'(s2_q_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_REST;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (head_valid) begin
        dir_r <= (dir_r == DIR_SOUTH) ? DIR_REST : dir_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dir_r  <= dir_r;
      s1_dx_r   <= dx_nxt;
      s1_dy_r   <= dy_nxt;
      s1_f_r    <= f_nxt;
      s1_eq_r   <= eq_nxt;
      s1_diff_r <= DW'(eq_nxt) - DW'(f_nxt);
      s1_src_r  <= head_entry.src;

      s2_dir_r  <= s1_dir_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_f_r    <= s1_f_r;
      s2_eq_r   <= s1_eq_r;
      s2_q_r    <= mulq(s1_diff_r, inv_tau);
      s2_src_r  <= s1_src_r;

      out_dir_r  <= s2_dir_r;
      out_dx_r   <= s2_dx_r;
      out_dy_r   <= s2_dy_r;
      out_post_r <= post_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_dir_r;
  assign out_tlast  = (out_dir_r == DIR_SOUTH);
  assign out_tdata  = {{(OUT_DATA_W - 2*CW - VW){1'b0}}, out_post_r, out_dy_r, out_dx_r};

endmodule

### rtl/core/lbm_d2q5_wave_collide_stream.sv
// D2Q5 lattice-Boltzmann wave block: one cell beat in, five streamed
// result beats out (rest, east, north, west, south; tlast on south). The
// single result channel, which the back end fills one direction per
// cycle while out_tready is high, sets the cell rate; new cells are taken
// while earlier ones are still in flight. A cell's result beats pass
// three front stages, the cell queue and three back stages. A four-entry
// queue lets the front keep taking cells while the result side stalls,
// until it fills. Values are signed Q8.16, saturated.
// Depends on lbmw_pkg, lbmw_front, lbmw_queue and lbmw_back.
module lbm_d2q5_wave_collide_stream import lbmw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cell_x[6:0], cell_y[13:7], f_rest[37:14], f_east[61:38],
  // f_north[85:62], f_west[109:86], f_south[133:110],
  // source_density[157:134], zero fill
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // is_source
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // dest_x[6:0], dest_y[13:7], post_value[37:14], zero fill
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // direction[2:0]
  output logic [DIRW-1:0]        out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [C2W-1:0] c_squared_r;
  logic [TW-1:0]  inv_tau_r;

  logic  f_valid, f_ready, h_valid, h_pop;
  cell_t f_entry, h_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_squared_r <= C_SQUARED_RST;
      inv_tau_r   <= INV_TAU_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_C_SQUARED: c_squared_r <= cfg_data[C2W-1:0];
        CFG_INV_TAU:   inv_tau_r   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  lbmw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .c_squared (c_squared_r),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_entry   (f_entry)
  );

  lbmw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .head_valid (h_valid),
    .pop        (h_pop),
    .head_entry (h_entry)
  );

  lbmw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (h_valid),
    .head_entry (h_entry),
    .pop        (h_pop),
    .inv_tau    (inv_tau_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
